>>> rtl/core/r2h_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r2h_pkg
// Shared types, constants and the romaji key ROM for the hiragana converter.
// ----------------------------------------------------------------------------
package r2h_pkg;

   localparam int MAX_MATCH = 4;
   localparam int CNT_W     = $clog2(MAX_MATCH + 1);
   localparam int IDX_W     = $clog2(MAX_MATCH);

   localparam logic [15:0] KANA_N         = 16'h3093;
   localparam logic [15:0] KANA_SMALL_TSU = 16'h3063;

   localparam logic [1:0] KIND_KANA   = 2'd0;
   localparam logic [1:0] KIND_RAW    = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [7:0] CH_APOS = 8'h27;
   localparam logic [7:0] CH_N    = 8'h6E;
   localparam logic [7:0] CH_Y    = 8'h79;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic       n_hit;    // syllabic n applies
      logic       n_two;    // the apostrophe after n is eaten too
      logic       dbl_hit;  // doubled consonant, small tsu
      logic       rom_hit;
      logic [15:0] k0;
      logic [15:0] k1;
   } decide_type;

   function automatic logic is_cons(input byte_type c);
      is_cons = (c >= "a") && (c <= "z") && (c != "a") && (c != "i") && (c != "u")
         && (c != "e") && (c != "o");
   endfunction

   // Key is the length followed by up to four bytes, first byte highest,
   // unused bytes zero. Result is {k0, k1}; zero means no entry.
   function automatic logic [31:0] rom_lookup(input logic [34:0] key);
      logic [31:0] kv;
      kv = 32'h0;
      unique case (key)
         {3'd1,"a",24'h0}: kv = 32'h3042_0000;  {3'd1,"i",24'h0}: kv = 32'h3044_0000;
         {3'd1,"u",24'h0}: kv = 32'h3046_0000;  {3'd1,"e",24'h0}: kv = 32'h3048_0000;
         {3'd1,"o",24'h0}: kv = 32'h304A_0000;  {3'd1,"-",24'h0}: kv = 32'h30FC_0000;
         {3'd2,"ka",16'h0}: kv = 32'h304B_0000; {3'd2,"ki",16'h0}: kv = 32'h304D_0000;
         {3'd2,"ku",16'h0}: kv = 32'h304F_0000; {3'd2,"ke",16'h0}: kv = 32'h3051_0000;
         {3'd2,"ko",16'h0}: kv = 32'h3053_0000; {3'd2,"ga",16'h0}: kv = 32'h304C_0000;
         {3'd2,"gi",16'h0}: kv = 32'h304E_0000; {3'd2,"gu",16'h0}: kv = 32'h3050_0000;
         {3'd2,"ge",16'h0}: kv = 32'h3052_0000; {3'd2,"go",16'h0}: kv = 32'h3054_0000;
         {3'd2,"sa",16'h0}: kv = 32'h3055_0000; {3'd3,"shi",8'h0}: kv = 32'h3057_0000;
         {3'd2,"si",16'h0}: kv = 32'h3057_0000; {3'd2,"su",16'h0}: kv = 32'h3059_0000;
         {3'd2,"se",16'h0}: kv = 32'h305B_0000; {3'd2,"so",16'h0}: kv = 32'h305D_0000;
         {3'd2,"za",16'h0}: kv = 32'h3056_0000; {3'd2,"ji",16'h0}: kv = 32'h3058_0000;
         {3'd2,"zi",16'h0}: kv = 32'h3058_0000; {3'd2,"zu",16'h0}: kv = 32'h305A_0000;
         {3'd2,"ze",16'h0}: kv = 32'h305C_0000; {3'd2,"zo",16'h0}: kv = 32'h305E_0000;
         {3'd2,"ta",16'h0}: kv = 32'h305F_0000; {3'd3,"chi",8'h0}: kv = 32'h3061_0000;
         {3'd2,"ti",16'h0}: kv = 32'h3061_0000; {3'd3,"tsu",8'h0}: kv = 32'h3064_0000;
         {3'd2,"tu",16'h0}: kv = 32'h3064_0000; {3'd2,"te",16'h0}: kv = 32'h3066_0000;
         {3'd2,"to",16'h0}: kv = 32'h3068_0000; {3'd2,"da",16'h0}: kv = 32'h3060_0000;
         {3'd2,"di",16'h0}: kv = 32'h3062_0000; {3'd2,"du",16'h0}: kv = 32'h3065_0000;
         {3'd2,"de",16'h0}: kv = 32'h3067_0000; {3'd2,"do",16'h0}: kv = 32'h3069_0000;
         {3'd2,"na",16'h0}: kv = 32'h306A_0000; {3'd2,"ni",16'h0}: kv = 32'h306B_0000;
         {3'd2,"nu",16'h0}: kv = 32'h306C_0000; {3'd2,"ne",16'h0}: kv = 32'h306D_0000;
         {3'd2,"no",16'h0}: kv = 32'h306E_0000; {3'd2,"ha",16'h0}: kv = 32'h306F_0000;
         {3'd2,"hi",16'h0}: kv = 32'h3072_0000; {3'd2,"fu",16'h0}: kv = 32'h3075_0000;
         {3'd2,"hu",16'h0}: kv = 32'h3075_0000; {3'd2,"he",16'h0}: kv = 32'h3078_0000;
         {3'd2,"ho",16'h0}: kv = 32'h307B_0000; {3'd2,"ba",16'h0}: kv = 32'h3070_0000;
         {3'd2,"bi",16'h0}: kv = 32'h3073_0000; {3'd2,"bu",16'h0}: kv = 32'h3076_0000;
         {3'd2,"be",16'h0}: kv = 32'h3079_0000; {3'd2,"bo",16'h0}: kv = 32'h307C_0000;
         {3'd2,"pa",16'h0}: kv = 32'h3071_0000; {3'd2,"pi",16'h0}: kv = 32'h3074_0000;
         {3'd2,"pu",16'h0}: kv = 32'h3077_0000; {3'd2,"pe",16'h0}: kv = 32'h307A_0000;
         {3'd2,"po",16'h0}: kv = 32'h307D_0000; {3'd2,"ma",16'h0}: kv = 32'h307E_0000;
         {3'd2,"mi",16'h0}: kv = 32'h307F_0000; {3'd2,"mu",16'h0}: kv = 32'h3080_0000;
         {3'd2,"me",16'h0}: kv = 32'h3081_0000; {3'd2,"mo",16'h0}: kv = 32'h3082_0000;
         {3'd2,"ya",16'h0}: kv = 32'h3084_0000; {3'd2,"yu",16'h0}: kv = 32'h3086_0000;
         {3'd2,"yo",16'h0}: kv = 32'h3088_0000; {3'd2,"ra",16'h0}: kv = 32'h3089_0000;
         {3'd2,"ri",16'h0}: kv = 32'h308A_0000; {3'd2,"ru",16'h0}: kv = 32'h308B_0000;
         {3'd2,"re",16'h0}: kv = 32'h308C_0000; {3'd2,"ro",16'h0}: kv = 32'h308D_0000;
         {3'd2,"wa",16'h0}: kv = 32'h308F_0000; {3'd2,"wo",16'h0}: kv = 32'h3092_0000;
         {3'd2,"nn",16'h0}: kv = 32'h3093_0000;
         {3'd3,"kya",8'h0}: kv = 32'h304D_3083; {3'd3,"kyu",8'h0}: kv = 32'h304D_3085;
         {3'd3,"kyo",8'h0}: kv = 32'h304D_3087; {3'd3,"gya",8'h0}: kv = 32'h304E_3083;
         {3'd3,"gyu",8'h0}: kv = 32'h304E_3085; {3'd3,"gyo",8'h0}: kv = 32'h304E_3087;
         {3'd3,"sha",8'h0}: kv = 32'h3057_3083; {3'd3,"shu",8'h0}: kv = 32'h3057_3085;
         {3'd3,"sho",8'h0}: kv = 32'h3057_3087; {3'd3,"sya",8'h0}: kv = 32'h3057_3083;
         {3'd3,"syu",8'h0}: kv = 32'h3057_3085; {3'd3,"syo",8'h0}: kv = 32'h3057_3087;
         {3'd2,"ja",16'h0}: kv = 32'h3058_3083; {3'd2,"ju",16'h0}: kv = 32'h3058_3085;
         {3'd2,"jo",16'h0}: kv = 32'h3058_3087; {3'd3,"jya",8'h0}: kv = 32'h3058_3083;
         {3'd3,"jyu",8'h0}: kv = 32'h3058_3085; {3'd3,"jyo",8'h0}: kv = 32'h3058_3087;
         {3'd3,"cha",8'h0}: kv = 32'h3061_3083; {3'd3,"chu",8'h0}: kv = 32'h3061_3085;
         {3'd3,"cho",8'h0}: kv = 32'h3061_3087; {3'd3,"cya",8'h0}: kv = 32'h3061_3083;
         {3'd3,"cyu",8'h0}: kv = 32'h3061_3085; {3'd3,"cyo",8'h0}: kv = 32'h3061_3087;
         {3'd3,"tya",8'h0}: kv = 32'h3061_3083; {3'd3,"tyu",8'h0}: kv = 32'h3061_3085;
         {3'd3,"tyo",8'h0}: kv = 32'h3061_3087; {3'd3,"nya",8'h0}: kv = 32'h306B_3083;
         {3'd3,"nyu",8'h0}: kv = 32'h306B_3085; {3'd3,"nyo",8'h0}: kv = 32'h306B_3087;
         {3'd3,"hya",8'h0}: kv = 32'h3072_3083; {3'd3,"hyu",8'h0}: kv = 32'h3072_3085;
         {3'd3,"hyo",8'h0}: kv = 32'h3072_3087; {3'd3,"bya",8'h0}: kv = 32'h3073_3083;
         {3'd3,"byu",8'h0}: kv = 32'h3073_3085; {3'd3,"byo",8'h0}: kv = 32'h3073_3087;
         {3'd3,"pya",8'h0}: kv = 32'h3074_3083; {3'd3,"pyu",8'h0}: kv = 32'h3074_3085;
         {3'd3,"pyo",8'h0}: kv = 32'h3074_3087; {3'd3,"mya",8'h0}: kv = 32'h307F_3083;
         {3'd3,"myu",8'h0}: kv = 32'h307F_3085; {3'd3,"myo",8'h0}: kv = 32'h307F_3087;
         {3'd3,"rya",8'h0}: kv = 32'h308A_3083; {3'd3,"ryu",8'h0}: kv = 32'h308A_3085;
         {3'd3,"ryo",8'h0}: kv = 32'h308A_3087;
         {3'd2,"fa",16'h0}: kv = 32'h3075_3041; {3'd2,"fi",16'h0}: kv = 32'h3075_3043;
         {3'd2,"fe",16'h0}: kv = 32'h3075_3047; {3'd2,"fo",16'h0}: kv = 32'h3075_3049;
         {3'd2,"va",16'h0}: kv = 32'h3094_3041; {3'd2,"vi",16'h0}: kv = 32'h3094_3043;
         {3'd2,"vu",16'h0}: kv = 32'h3094_0000; {3'd2,"ve",16'h0}: kv = 32'h3094_3047;
         {3'd2,"vo",16'h0}: kv = 32'h3094_3049;
         {3'd2,"wi",16'h0}: kv = 32'h3046_3043; {3'd2,"we",16'h0}: kv = 32'h3046_3047;
         {3'd3,"she",8'h0}: kv = 32'h3057_3047; {3'd2,"je",16'h0}: kv = 32'h3058_3047;
         {3'd3,"che",8'h0}: kv = 32'h3061_3047;
         {3'd3,"tsa",8'h0}: kv = 32'h3064_3041; {3'd3,"tsi",8'h0}: kv = 32'h3064_3043;
         {3'd3,"tse",8'h0}: kv = 32'h3064_3047; {3'd3,"tso",8'h0}: kv = 32'h3064_3049;
         {3'd3,"thi",8'h0}: kv = 32'h3066_3043; {3'd3,"dhi",8'h0}: kv = 32'h3067_3043;
         {3'd3,"twu",8'h0}: kv = 32'h3068_3045; {3'd3,"dwu",8'h0}: kv = 32'h3069_3045;
         {3'd3,"kwa",8'h0}: kv = 32'h304F_3041; {3'd3,"gwa",8'h0}: kv = 32'h3050_3041;
         {3'd2,"xa",16'h0}: kv = 32'h3041_0000; {3'd2,"xi",16'h0}: kv = 32'h3043_0000;
         {3'd2,"xu",16'h0}: kv = 32'h3045_0000; {3'd2,"xe",16'h0}: kv = 32'h3047_0000;
         {3'd2,"xo",16'h0}: kv = 32'h3049_0000; {3'd2,"la",16'h0}: kv = 32'h3041_0000;
         {3'd2,"li",16'h0}: kv = 32'h3043_0000; {3'd2,"lu",16'h0}: kv = 32'h3045_0000;
         {3'd2,"le",16'h0}: kv = 32'h3047_0000; {3'd2,"lo",16'h0}: kv = 32'h3049_0000;
         {3'd3,"xya",8'h0}: kv = 32'h3083_0000; {3'd3,"xyu",8'h0}: kv = 32'h3085_0000;
         {3'd3,"xyo",8'h0}: kv = 32'h3087_0000; {3'd3,"lya",8'h0}: kv = 32'h3083_0000;
         {3'd3,"lyu",8'h0}: kv = 32'h3085_0000; {3'd3,"lyo",8'h0}: kv = 32'h3087_0000;
         {3'd4,"xtsu"}: kv = 32'h3063_0000;     {3'd4,"ltsu"}: kv = 32'h3063_0000;
         {3'd3,"xwa",8'h0}: kv = 32'h308E_0000;
         default: kv = 32'h0;
      endcase
      rom_lookup = kv;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/r2h_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r2h_decide
// Rule checks on the buffer head and one ROM probe at the length asked for.
// ----------------------------------------------------------------------------
module r2h_decide
   import r2h_pkg::*;
(
   input  var byte_type           buf_b0,
   input  var byte_type           buf_b1,
   input  var byte_type           buf_b2,
   input  var byte_type           buf_b3,
   input  var logic [CNT_W-1:0]   count,
   input  var logic [CNT_W-1:0]   probe_len,
   output decide_type             result
);

   logic [31:0] kv;
   logic [34:0] key;

   always_comb begin
      key = {probe_len, buf_b0,
             (probe_len >= 3'd2) ? buf_b1 : 8'h00,
             (probe_len >= 3'd3) ? buf_b2 : 8'h00,
             (probe_len >= 3'd4) ? buf_b3 : 8'h00};
      kv = rom_lookup(key);
   end

   always_comb begin
      result.n_hit = (buf_b0 == CH_N) && ((count == 3'd1) || (buf_b1 == CH_APOS)
         || (buf_b1 == CH_N) || (is_cons(buf_b1) && (buf_b1 != CH_Y)));
      result.n_two   = (count != 3'd1) && (buf_b1 == CH_APOS);
      result.dbl_hit = (count >= 3'd2) && (buf_b0 == buf_b1) && is_cons(buf_b0)
         && (buf_b0 != CH_N);
      result.rom_hit = (kv[31:16] != 16'h0);
      result.k0      = kv[31:16];
      result.k1      = kv[15:0];
   end

endmodule
`default_nettype wire

>>> rtl/core/romaji_to_hiragana_stream.sv
`default_nettype none
// ----------------------------------------------------------------------------
// romaji_to_hiragana_stream
// Romaji byte stream in, hiragana codepoints, raw bytes and status out.
// ----------------------------------------------------------------------------
// Sequence: a byte that gives no result is only buffered. A decision runs the
// rule check in S_RULE, then one ROM probe per key length tried in S_ROM
// (longest first, the hit emits the first kana), S_KANA2 for a second kana and
// S_DUMP per raw byte; each step waits while a result is held and not taken.
// Throughput: one byte at a time; req_tready is low until its results are out.
// Reset (synchronous) clears the sequencer, buffer count and string flags.
// ----------------------------------------------------------------------------
module romaji_to_hiragana_stream
   import r2h_pkg::*;
(
   input  var logic        clock,
   input  var logic        reset,
   input  var logic        req_tvalid,
   output logic            req_tready,
   input  var logic [7:0]  req_tdata,   // [7:0] char_in
   input  var logic        req_tlast,   // end_of_text
   output logic            rsp_tvalid,
   input  var logic        rsp_tready,
   output logic [23:0]     rsp_tdata,   // [15:0] code, [16] complete, rest zero
   output logic [1:0]      rsp_tuser,   // [1:0] kind
   output logic            rsp_tlast    // last_of_run
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_RAW    = 7'b0000010,
      S_RULE   = 7'b0000100,
      S_ROM    = 7'b0001000,
      S_KANA2  = 7'b0010000,
      S_DUMP   = 7'b0100000,
      S_STATUS = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   byte_type           buf_ff [MAX_MATCH], buf_in [MAX_MATCH];
   logic [CNT_W-1:0]   cnt_ff, cnt_in, len_ff, len_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               pend_ff, pend_in, seen_ff, seen_in, eot_ff, eot_in;
   byte_type           ch_ff, ch_in;
   logic [15:0]        k1_ff, k1_in;
   logic               ov_ff, ov_in;
   logic [1:0]         okind_ff, okind_in;
   logic [15:0]        ocode_ff, ocode_in;
   logic               ocmp_ff, ocmp_in, olast_ff, olast_in;

   decide_type         dec;
   byte_type           lc;
   logic               out_free;
   logic [CNT_W-1:0]   used, left, wr_pos;

   r2h_decide u_decide (
      .buf_b0    (buf_ff[0]),
      .buf_b1    (buf_ff[1]),
      .buf_b2    (buf_ff[2]),
      .buf_b3    (buf_ff[3]),
      .count     (cnt_ff),
      .probe_len (len_ff),
      .result    (dec)
   );

   assign out_free   = !ov_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign lc = ((req_tdata >= "A") && (req_tdata <= "Z")) ? (req_tdata + 8'd32) : req_tdata;
   assign wr_pos = (cnt_ff >= CNT_W'(MAX_MATCH)) ? CNT_W'(MAX_MATCH - 1) : cnt_ff;

   always_comb begin
      state_in = state_ff;
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      pend_in  = pend_ff;
      seen_in  = seen_ff;
      eot_in   = eot_ff;
      ch_in    = ch_ff;
      k1_in    = k1_ff;
      ov_in    = ov_ff && !rsp_tready;
      okind_in = okind_ff;
      ocode_in = ocode_ff;
      ocmp_in  = ocmp_ff;
      olast_in = olast_ff;
      used     = '0;
      left     = cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               eot_in = req_tlast;
               ch_in  = lc;
               if (pend_ff) begin
                  state_in = S_RAW;
               end else begin
                  buf_in[wr_pos[IDX_W-1:0]] = lc;
                  cnt_in = wr_pos + 3'd1;
                  if (req_tlast || (wr_pos + 3'd1 == CNT_W'(MAX_MATCH))) begin
                     state_in = S_RULE;
                  end
               end
            end
         end
         S_RAW: begin
            if (out_free) begin
               ov_in    = 1'b1;
               okind_in = KIND_RAW;
               ocode_in = {8'h00, ch_ff};
               ocmp_in  = 1'b0;
               olast_in = !eot_ff;
               state_in = eot_ff ? S_STATUS : S_IDLE;
            end
         end
         S_RULE: begin
            if (out_free) begin
               if (dec.n_hit || dec.dbl_hit) begin
                  used     = (dec.n_hit && dec.n_two) ? 3'd2 : 3'd1;
                  ov_in    = 1'b1;
                  okind_in = KIND_KANA;
                  ocode_in = dec.n_hit ? KANA_N : KANA_SMALL_TSU;
                  ocmp_in  = 1'b0;
                  olast_in = !eot_ff;
                  seen_in  = 1'b1;
               end else begin
                  len_in   = cnt_ff;
                  state_in = S_ROM;
               end
            end
         end
         S_ROM: begin
            if (out_free) begin
               if (dec.rom_hit) begin
                  used     = len_ff;
                  ov_in    = 1'b1;
                  okind_in = KIND_KANA;
                  ocode_in = dec.k0;
                  ocmp_in  = 1'b0;
                  olast_in = !eot_ff && (dec.k1 == 16'h0);
                  seen_in  = 1'b1;
                  k1_in    = dec.k1;
               end else if (len_ff == 3'd1) begin
                  pend_in  = 1'b1;
                  idx_in   = '0;
                  state_in = S_DUMP;
               end else begin
                  len_in = len_ff - 3'd1;
               end
            end
         end
         S_KANA2: begin
            if (out_free) begin
               ov_in    = 1'b1;
               okind_in = KIND_KANA;
               ocode_in = k1_ff;
               ocmp_in  = 1'b0;
               olast_in = !eot_ff;
               if (!eot_ff) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = (cnt_ff != '0) ? S_RULE : S_STATUS;
               end
            end
         end
         S_DUMP: begin
            if (out_free) begin
               ov_in    = 1'b1;
               okind_in = KIND_RAW;
               ocode_in = {8'h00, buf_ff[idx_ff]};
               ocmp_in  = 1'b0;
               olast_in = 1'b0;
               idx_in   = idx_ff + 1'b1;
               if ({1'b0, idx_ff} == cnt_ff - 3'd1) begin
                  olast_in = !eot_ff;
                  cnt_in   = '0;
                  state_in = eot_ff ? S_STATUS : S_IDLE;
               end
            end
         end
         S_STATUS: begin
            if (out_free) begin
               ov_in    = 1'b1;
               okind_in = KIND_STATUS;
               ocode_in = 16'h0;
               ocmp_in  = seen_ff && !pend_ff;
               olast_in = 1'b1;
               cnt_in   = '0;
               pend_in  = 1'b0;
               seen_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A decision that consumed bytes shifts the buffer down.
      if (used != '0) begin
         left = cnt_ff - used;
         for (int i = 0; i < MAX_MATCH; i++) begin
            if (i + int'(used) < MAX_MATCH) begin
               buf_in[i] = buf_ff[i + int'(used)];
            end
         end
         cnt_in = left;
         if (state_ff == S_ROM && dec.k1 != 16'h0) begin
            state_in = S_KANA2;
         end else if (!eot_ff) begin
            state_in = S_IDLE;
         end else begin
            state_in = (left != '0) ? S_RULE : S_STATUS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         seen_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         seen_ff  <= seen_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff   <= buf_in;
      len_ff   <= len_in;
      idx_ff   <= idx_in;
      eot_ff   <= eot_in;
      ch_ff    <= ch_in;
      k1_ff    <= k1_in;
      okind_ff <= okind_in;
      ocode_ff <= ocode_in;
      ocmp_ff  <= ocmp_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {7'h00, ocmp_ff, ocode_ff};
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Romaji-to-hiragana stream converter bench. Romaji strings, broken strings
// and raw noise go in one request per byte. A shadow model of the lookahead
// buffer predicts every kana, raw echo and status result, and each result is
// compared with the oldest prediction while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   import r2h_pkg::*;

   typedef struct {
      logic [7:0] ch;
      logic       eot;
   } char_req_type;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] code;
      logic        complete;
      logic        last;
   } conv_out_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] char_in
   logic        req_tlast;    // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // [15:0] code, [16] complete, rest zero
   logic [1:0]  rsp_tuser;    // [1:0] kind
   logic        rsp_tlast;    // last_of_run

   romaji_to_hiragana_stream uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   char_req_type  char_pending[$];
   conv_out_type  conv_expected[$];
   logic [31:0]   kana_table[string];
   int            error_count = 0;
   int            idle_cycles = 0;

   // Shadow state of the converter.
   logic [7:0]  la_buf[4];
   int          la_count;
   bit          raw_echo;
   bit          any_kana;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic load_kana_table();
      kana_table["a"]=32'h3042_0000; kana_table["i"]=32'h3044_0000;
      kana_table["u"]=32'h3046_0000; kana_table["e"]=32'h3048_0000;
      kana_table["o"]=32'h304A_0000; kana_table["-"]=32'h30FC_0000;
      kana_table["ka"]=32'h304B_0000; kana_table["ki"]=32'h304D_0000;
      kana_table["ku"]=32'h304F_0000; kana_table["ke"]=32'h3051_0000;
      kana_table["ko"]=32'h3053_0000; kana_table["ga"]=32'h304C_0000;
      kana_table["gi"]=32'h304E_0000; kana_table["gu"]=32'h3050_0000;
      kana_table["ge"]=32'h3052_0000; kana_table["go"]=32'h3054_0000;
      kana_table["sa"]=32'h3055_0000; kana_table["shi"]=32'h3057_0000;
      kana_table["si"]=32'h3057_0000; kana_table["su"]=32'h3059_0000;
      kana_table["se"]=32'h305B_0000; kana_table["so"]=32'h305D_0000;
      kana_table["za"]=32'h3056_0000; kana_table["ji"]=32'h3058_0000;
      kana_table["zi"]=32'h3058_0000; kana_table["zu"]=32'h305A_0000;
      kana_table["ze"]=32'h305C_0000; kana_table["zo"]=32'h305E_0000;
      kana_table["ta"]=32'h305F_0000; kana_table["chi"]=32'h3061_0000;
      kana_table["ti"]=32'h3061_0000; kana_table["tsu"]=32'h3064_0000;
      kana_table["tu"]=32'h3064_0000; kana_table["te"]=32'h3066_0000;
      kana_table["to"]=32'h3068_0000; kana_table["da"]=32'h3060_0000;
      kana_table["di"]=32'h3062_0000; kana_table["du"]=32'h3065_0000;
      kana_table["de"]=32'h3067_0000; kana_table["do"]=32'h3069_0000;
      kana_table["na"]=32'h306A_0000; kana_table["ni"]=32'h306B_0000;
      kana_table["nu"]=32'h306C_0000; kana_table["ne"]=32'h306D_0000;
      kana_table["no"]=32'h306E_0000; kana_table["ha"]=32'h306F_0000;
      kana_table["hi"]=32'h3072_0000; kana_table["fu"]=32'h3075_0000;
      kana_table["hu"]=32'h3075_0000; kana_table["he"]=32'h3078_0000;
      kana_table["ho"]=32'h307B_0000; kana_table["ba"]=32'h3070_0000;
      kana_table["bi"]=32'h3073_0000; kana_table["bu"]=32'h3076_0000;
      kana_table["be"]=32'h3079_0000; kana_table["bo"]=32'h307C_0000;
      kana_table["pa"]=32'h3071_0000; kana_table["pi"]=32'h3074_0000;
      kana_table["pu"]=32'h3077_0000; kana_table["pe"]=32'h307A_0000;
      kana_table["po"]=32'h307D_0000; kana_table["ma"]=32'h307E_0000;
      kana_table["mi"]=32'h307F_0000; kana_table["mu"]=32'h3080_0000;
      kana_table["me"]=32'h3081_0000; kana_table["mo"]=32'h3082_0000;
      kana_table["ya"]=32'h3084_0000; kana_table["yu"]=32'h3086_0000;
      kana_table["yo"]=32'h3088_0000; kana_table["ra"]=32'h3089_0000;
      kana_table["ri"]=32'h308A_0000; kana_table["ru"]=32'h308B_0000;
      kana_table["re"]=32'h308C_0000; kana_table["ro"]=32'h308D_0000;
      kana_table["wa"]=32'h308F_0000; kana_table["wo"]=32'h3092_0000;
      kana_table["nn"]=32'h3093_0000;
      kana_table["kya"]=32'h304D_3083; kana_table["kyu"]=32'h304D_3085;
      kana_table["kyo"]=32'h304D_3087; kana_table["gya"]=32'h304E_3083;
      kana_table["gyu"]=32'h304E_3085; kana_table["gyo"]=32'h304E_3087;
      kana_table["sha"]=32'h3057_3083; kana_table["shu"]=32'h3057_3085;
      kana_table["sho"]=32'h3057_3087; kana_table["sya"]=32'h3057_3083;
      kana_table["syu"]=32'h3057_3085; kana_table["syo"]=32'h3057_3087;
      kana_table["ja"]=32'h3058_3083; kana_table["ju"]=32'h3058_3085;
      kana_table["jo"]=32'h3058_3087; kana_table["jya"]=32'h3058_3083;
      kana_table["jyu"]=32'h3058_3085; kana_table["jyo"]=32'h3058_3087;
      kana_table["cha"]=32'h3061_3083; kana_table["chu"]=32'h3061_3085;
      kana_table["cho"]=32'h3061_3087; kana_table["cya"]=32'h3061_3083;
      kana_table["cyu"]=32'h3061_3085; kana_table["cyo"]=32'h3061_3087;
      kana_table["tya"]=32'h3061_3083; kana_table["tyu"]=32'h3061_3085;
      kana_table["tyo"]=32'h3061_3087; kana_table["nya"]=32'h306B_3083;
      kana_table["nyu"]=32'h306B_3085; kana_table["nyo"]=32'h306B_3087;
      kana_table["hya"]=32'h3072_3083; kana_table["hyu"]=32'h3072_3085;
      kana_table["hyo"]=32'h3072_3087; kana_table["bya"]=32'h3073_3083;
      kana_table["byu"]=32'h3073_3085; kana_table["byo"]=32'h3073_3087;
      kana_table["pya"]=32'h3074_3083; kana_table["pyu"]=32'h3074_3085;
      kana_table["pyo"]=32'h3074_3087; kana_table["mya"]=32'h307F_3083;
      kana_table["myu"]=32'h307F_3085; kana_table["myo"]=32'h307F_3087;
      kana_table["rya"]=32'h308A_3083; kana_table["ryu"]=32'h308A_3085;
      kana_table["ryo"]=32'h308A_3087;
      kana_table["fa"]=32'h3075_3041; kana_table["fi"]=32'h3075_3043;
      kana_table["fe"]=32'h3075_3047; kana_table["fo"]=32'h3075_3049;
      kana_table["va"]=32'h3094_3041; kana_table["vi"]=32'h3094_3043;
      kana_table["vu"]=32'h3094_0000; kana_table["ve"]=32'h3094_3047;
      kana_table["vo"]=32'h3094_3049;
      kana_table["wi"]=32'h3046_3043; kana_table["we"]=32'h3046_3047;
      kana_table["she"]=32'h3057_3047; kana_table["je"]=32'h3058_3047;
      kana_table["che"]=32'h3061_3047;
      kana_table["tsa"]=32'h3064_3041; kana_table["tsi"]=32'h3064_3043;
      kana_table["tse"]=32'h3064_3047; kana_table["tso"]=32'h3064_3049;
      kana_table["thi"]=32'h3066_3043; kana_table["dhi"]=32'h3067_3043;
      kana_table["twu"]=32'h3068_3045; kana_table["dwu"]=32'h3069_3045;
      kana_table["kwa"]=32'h304F_3041; kana_table["gwa"]=32'h3050_3041;
      kana_table["xa"]=32'h3041_0000; kana_table["xi"]=32'h3043_0000;
      kana_table["xu"]=32'h3045_0000; kana_table["xe"]=32'h3047_0000;
      kana_table["xo"]=32'h3049_0000; kana_table["la"]=32'h3041_0000;
      kana_table["li"]=32'h3043_0000; kana_table["lu"]=32'h3045_0000;
      kana_table["le"]=32'h3047_0000; kana_table["lo"]=32'h3049_0000;
      kana_table["xya"]=32'h3083_0000; kana_table["xyu"]=32'h3085_0000;
      kana_table["xyo"]=32'h3087_0000; kana_table["lya"]=32'h3083_0000;
      kana_table["lyu"]=32'h3085_0000; kana_table["lyo"]=32'h3087_0000;
      kana_table["xtsu"]=32'h3063_0000; kana_table["ltsu"]=32'h3063_0000;
      kana_table["xwa"]=32'h308E_0000;
   endtask

   function automatic bit consonant(input logic [7:0] c);
      return c >= "a" && c <= "z" && c != "a" && c != "i" && c != "u" && c != "e"
         && c != "o";
   endfunction

   function automatic void push_result(input logic [1:0] kind, input logic [15:0] code,
                                       input logic complete);
      conv_out_type r;
      r.kind = kind;
      r.code = code;
      r.complete = complete;
      r.last = 1'b0;
      conv_expected.push_back(r);
      if (kind == KIND_KANA) any_kana = 1'b1;
   endfunction

   // Returns the number of buffered bytes one decision uses, 0 for no match.
   function automatic int decide_head();
      string       key;
      logic [31:0] kv;
      bit          bad;
      if (la_buf[0] == CH_N) begin
         if (la_count == 1) begin
            push_result(KIND_KANA, KANA_N, 1'b0);
            return 1;
         end
         if (la_buf[1] == CH_APOS) begin
            push_result(KIND_KANA, KANA_N, 1'b0);
            return 2;
         end
         if (la_buf[1] == CH_N || (consonant(la_buf[1]) && la_buf[1] != CH_Y)) begin
            push_result(KIND_KANA, KANA_N, 1'b0);
            return 1;
         end
      end
      if (la_count >= 2 && la_buf[0] == la_buf[1] && consonant(la_buf[0])
          && la_buf[0] != CH_N) begin
         push_result(KIND_KANA, KANA_SMALL_TSU, 1'b0);
         return 1;
      end
      for (int len = la_count; len > 0; len--) begin
         key = "";
         bad = 1'b0;
         for (int i = 0; i < len; i++) begin
            if (la_buf[i] == 8'h00) bad = 1'b1;
            key = {key, string'(la_buf[i])};
         end
         if (!bad && kana_table.exists(key)) begin
            kv = kana_table[key];
            push_result(KIND_KANA, kv[31:16], 1'b0);
            if (kv[15:0] != 16'h0) push_result(KIND_KANA, kv[15:0], 1'b0);
            return len;
         end
      end
      return 0;
   endfunction

   function automatic void advance_buffer();
      int used;
      used = decide_head();
      if (used == 0 || used > la_count) begin
         for (int i = 0; i < la_count; i++) push_result(KIND_RAW, {8'h0, la_buf[i]}, 1'b0);
         la_count = 0;
         raw_echo = 1'b1;
      end else begin
         for (int i = 0; i + used < la_count; i++) la_buf[i] = la_buf[i + used];
         la_count -= used;
      end
   endfunction

   function automatic void convert_byte(input logic [7:0] ch_in, input logic eot);
      logic [7:0] c;
      int         first;
      first = conv_expected.size();
      c = (ch_in >= "A" && ch_in <= "Z") ? ch_in + 8'd32 : ch_in;
      if (raw_echo) begin
         push_result(KIND_RAW, {8'h0, c}, 1'b0);
      end else begin
         if (la_count >= MAX_MATCH) la_count = MAX_MATCH - 1;
         la_buf[la_count] = c;
         la_count++;
         if (!eot && la_count == MAX_MATCH) advance_buffer();
      end
      if (eot) begin
         while (la_count > 0 && !raw_echo) advance_buffer();
         push_result(KIND_STATUS, 16'h0, any_kana && !raw_echo);
         la_count = 0;
         raw_echo = 1'b0;
         any_kana = 1'b0;
      end
      if (conv_expected.size() > first) conv_expected[$].last = 1'b1;
   endfunction

   function automatic void queue_string(input string s);
      char_req_type r;
      for (int i = 0; i < s.len(); i++) begin
         r.ch = s[i];
         r.eot = (i == s.len() - 1);
         char_pending.push_back(r);
      end
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Random string built mostly from syllables, with case changes and noise.
   function automatic string random_romaji();
      string pieces[] = '{"ka", "shi", "tsu", "kya", "n", "'", "kk", "tt", "xtsu",
                          "ltsu", "a", "-", "fo", "vu", "ja", "chi", "ryo", "nn",
                          "wo", "xwa", "y", "nya", "pp", "dhi", "e", "gwa", "ss"};
      string s, p;
      int    target;
      s = "";
      target = $urandom_range(1, 10);
      while (s.len() < target) begin
         if ($urandom_range(0, 99) < 7) begin
            p = string'(8'($urandom_range(1, 255)));
            if ($urandom_range(0, 3) == 0) p = string'(8'h00 + 8'($urandom_range(0, 0)));
         end else begin
            p = pieces[$urandom_range(0, pieces.size() - 1)];
            if ($urandom_range(0, 5) == 0) p = p.toupper();
         end
         s = {s, p};
      end
      return s;
   endfunction

   // Request side: the front item stays on the bus until it is accepted.
   bit req_taken;
   int req_gap;

   always @(posedge clock) begin
      req_taken <= 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         convert_byte(req_tdata, req_tlast);
         void'(char_pending.pop_front());
         req_taken <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = pick_gap();
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0 || char_pending.size() == 0) begin
            req_tvalid <= 1'b0;
            if (req_gap > 0) req_gap--;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= char_pending[0].ch;
            req_tlast <= char_pending[0].eot;
            req_gap = pick_gap();
         end
      end
   end

   int rsp_stall;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   always @(posedge clock) begin
      conv_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (conv_expected.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[15:0], 16'h0);
         end else begin
            want = conv_expected.pop_front();
            if (rsp_tuser != want.kind) report_mismatch("kind", rsp_tuser, want.kind);
            if (rsp_tdata[15:0] != want.code)
               report_mismatch("code", rsp_tdata[15:0], want.code);
            if (rsp_tdata[16] != want.complete)
               report_mismatch("complete", rsp_tdata[16], want.complete);
            if (rsp_tdata[23:17] != 7'h0)
               report_mismatch("spare bits", rsp_tdata[23:17], 16'h0);
            if (rsp_tlast != want.last) report_mismatch("last", rsp_tlast, want.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 3000) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      string directed[] = '{"KA", "n", "n'a", "nna", "kka", "xtsu", "kya", "ny",
                            "-", "shi", "NNN", "qka"};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      la_count = 0;
      raw_echo = 1'b0;
      any_kana = 1'b0;
      load_kana_table();
      foreach (directed[i]) queue_string(directed[i]);
      char_pending.push_back('{8'hFF, 1'b1});
      char_pending.push_back('{8'h00, 1'b0});
      char_pending.push_back('{8'h5A, 1'b1});
      while (char_pending.size() < 370) queue_string(random_romaji());
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (char_pending.size() == 0 && conv_expected.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0 && conv_expected.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
